[rtl/core/afcd_pkg.sv]
package afcd_pkg;

	localparam logic [7:0] TYPE_CHAR = 8'h53;
	localparam logic [7:0] DIGIT_LO  = 8'h30;
	localparam logic [7:0] DIGIT_HI  = 8'h39;
	localparam logic [7:0] SUM_MOD   = 8'd100;
	localparam logic [6:0] OVERHEAD  = 7'd5;
	localparam logic [6:0] TRAILER   = 7'd2;
	localparam logic [6:0] POS_MAX   = 7'd127;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_TYPE  = 3'd1,
		ST_LEN   = 3'd2,
		ST_DIGIT = 3'd3,
		ST_SUM   = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eom;
		logic [7:0] link;
	} in_item_t;

	typedef struct packed {
		logic       emit;
		logic       kind;
		logic [7:0] data;
		status_t    status;
		logic [7:0] link;
	} result_t;

	function automatic logic is_digit(logic [7:0] b);
		return (b >= DIGIT_LO) && (b <= DIGIT_HI);
	endfunction

	// acc stays below 100; the byte is folded mod 100 by compare and subtract
	function automatic logic [6:0] add_mod(logic [6:0] acc, logic [7:0] b);
		logic [7:0] r;
		logic [7:0] s;
		if (b >= 8'd200) begin
			r = b - 8'd200;
		end else if (b >= SUM_MOD) begin
			r = b - SUM_MOD;
		end else begin
			r = b;
		end
		s = {1'b0, acc} + r;
		if (s >= SUM_MOD) begin
			s = s - SUM_MOD;
		end
		return s[6:0];
	endfunction

	function automatic logic [6:0] times_ten(logic [3:0] d);
		return ({3'b000, d} << 3) + ({3'b000, d} << 1);
	endfunction

endpackage

[rtl/core/afcd_parser.sv]
module afcd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  afcd_pkg::in_item_t  item,
	output afcd_pkg::result_t   res
);

	logic [6:0]          pos_q;
	logic [6:0]          size_q;
	logic [6:0]          sum_q;
	logic [6:0]          check_q;
	afcd_pkg::status_t   err_q;

	logic [6:0]          pos_n;
	logic [6:0]          size_n;
	logic [6:0]          sum_n;
	logic [6:0]          check_n;
	afcd_pkg::status_t   err_n;
	afcd_pkg::status_t   st;
	logic [6:0]          size_m2;
	logic [3:0]          dval;
	logic                dig;
	logic                emit_pl;

	always_comb begin
		err_n   = err_q;
		sum_n   = sum_q;
		size_n  = size_q;
		check_n = check_q;
		emit_pl = 1'b0;
		dval    = item.data[3:0];
		dig     = afcd_pkg::is_digit(item.data);
		// only reached error-free with size at least 5, so no wrap
		size_m2 = size_q - afcd_pkg::TRAILER;

		if (err_q == afcd_pkg::ST_OK) begin
			if (pos_q == 7'd0) begin
				if (item.data != afcd_pkg::TYPE_CHAR) begin
					err_n = afcd_pkg::ST_TYPE;
				end
				sum_n = afcd_pkg::add_mod(7'd0, item.data);
			end else if (pos_q == 7'd1 || pos_q == 7'd2) begin
				if (!dig) begin
					err_n = afcd_pkg::ST_DIGIT;
				end else begin
					sum_n = afcd_pkg::add_mod(sum_q, item.data);
					if (pos_q == 7'd1) begin
						size_n = afcd_pkg::times_ten(dval);
					end else begin
						size_n = size_q + {3'b000, dval};
						if (size_n < afcd_pkg::OVERHEAD) begin
							err_n = afcd_pkg::ST_LEN;
						end
					end
				end
			end else if (pos_q < size_m2) begin
				sum_n   = afcd_pkg::add_mod(sum_q, item.data);
				emit_pl = 1'b1;
			end else if (pos_q < size_q) begin
				if (!dig) begin
					err_n = afcd_pkg::ST_DIGIT;
				end else if (pos_q == size_m2) begin
					check_n = afcd_pkg::times_ten(dval);
				end else begin
					check_n = check_q + {3'b000, dval};
				end
			end else begin
				err_n = afcd_pkg::ST_LEN;
			end
		end

		pos_n = (pos_q != afcd_pkg::POS_MAX) ? pos_q + 7'd1 : pos_q;

		st = err_n;
		if (err_n == afcd_pkg::ST_OK) begin
			if (pos_q < 7'd2 || ({1'b0, pos_q} + 8'd1) != {1'b0, size_n}) begin
				st = afcd_pkg::ST_LEN;
			end else if (check_n != sum_n) begin
				st = afcd_pkg::ST_SUM;
			end
		end

		res.link = item.link;
		if (item.eom) begin
			res.emit   = 1'b1;
			res.kind   = 1'b1;
			res.data   = 8'd0;
			res.status = st;
		end else begin
			res.emit   = emit_pl;
			res.kind   = 1'b0;
			res.data   = item.data;
			res.status = afcd_pkg::ST_OK;
		end
	end

	// the last byte of a message returns everything to the reset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			size_q  <= '0;
			sum_q   <= '0;
			check_q <= '0;
			err_q   <= afcd_pkg::ST_OK;
		end else if (advance) begin
			if (item.eom) begin
				pos_q   <= '0;
				size_q  <= '0;
				sum_q   <= '0;
				check_q <= '0;
				err_q   <= afcd_pkg::ST_OK;
			end else begin
				pos_q   <= pos_n;
				size_q  <= size_n;
				sum_q   <= sum_n;
				check_q <= check_n;
				err_q   <= err_n;
			end
		end
	end

endmodule

[rtl/core/ascii_frame_checksum_deframer_core.sv]
// a result is registered in the result register; its byte waits in the input register on a stall
// throughput: one byte per cycle unless the output stalls; each byte takes one pass
// through the parser between the input register and the result register
// a byte that produces no result still occupies that single pass
// reset: arst_n clears both valid flags and the frame state asynchronously
module ascii_frame_checksum_deframer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] byte_in,
	input  logic       end_of_message,
	input  logic [7:0] link_id,
	output logic       result_valid,
	input  logic       result_stall,
	output logic       out_kind,
	output logic [7:0] payload_byte,
	output logic [2:0] status,
	output logic [7:0] link_out
);

	logic                valid_s1;
	afcd_pkg::in_item_t  item_s1;
	logic                out_valid_q;
	logic                kind_q;
	logic [7:0]          data_q;
	afcd_pkg::status_t   status_q;
	logic [7:0]          link_q;
	logic                out_free;
	logic                advance;
	afcd_pkg::result_t   res;

	assign out_free   = !out_valid_q || !result_stall;
	assign advance    = valid_s1 && out_free;
	assign byte_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			item_s1.data <= byte_in;
			item_s1.eom  <= end_of_message;
			item_s1.link <= link_id;
		end
	end

	afcd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			kind_q   <= res.kind;
			data_q   <= res.data;
			status_q <= res.status;
			link_q   <= res.link;
		end
	end

	assign result_valid = out_valid_q;
	assign out_kind     = kind_q;
	assign payload_byte = data_q;
	assign status       = status_q;
	assign link_out     = link_q;

`ifndef SYNTH
	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	a_payload_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !out_kind) |-> (status == afcd_pkg::ST_OK))
		else $error("payload transaction carries a nonzero status");

	a_status_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && out_kind) |-> (payload_byte == 8'd0))
		else $error("status transaction carries payload data");

	a_no_result_without_item: assert property (@(posedge clk) disable iff (!arst_n)
		(!result_valid && !valid_s1) |=> !result_valid)
		else $error("result appeared without an item in flight");
`endif

endmodule
